/* rtl/core/gga_pkg.sv */
// Shared types and constants for the group-average smoothing block.
`default_nettype none

package gga_pkg;

    localparam int DATA_W  = 32;  // Q16.16 word
    localparam int ADDR_W  = 6;   // sample slot address
    localparam int CNT_W   = 7;   // sample count, 0..64
    localparam int DIV_W   = 4;   // final chunk size, 1..8
    localparam int SUM_W   = 36;  // sum of up to eight words
    localparam int FEAT_N  = 4;   // feature lanes on the ports
    localparam int R_W     = 4;   // grid side r, 1..8
    localparam logic [1:0] KEYS_RESET = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] key_a;
        logic signed [DATA_W-1:0] key_b;
        logic signed [DATA_W-1:0] feat_a;
        logic signed [DATA_W-1:0] feat_b;
        logic signed [DATA_W-1:0] feat_c;
        logic signed [DATA_W-1:0] feat_d;
        logic                     final_sample;
    } t_sample;

    typedef struct packed {
        logic signed [DATA_W-1:0] mean_a;
        logic signed [DATA_W-1:0] mean_b;
        logic signed [DATA_W-1:0] mean_c;
        logic signed [DATA_W-1:0] mean_d;
        logic [ADDR_W-1:0]        source_slot;
        logic                     run_end;
    } t_result;

    // Store write from the front end.
    typedef struct packed {
        logic                           en;
        logic [ADDR_W-1:0]              addr;
        logic [1:0][DATA_W-1:0]         keys;
        logic [FEAT_N-1:0][DATA_W-1:0]  feats;
    } t_wr;

    // One grouping job.
    typedef struct packed {
        logic             two_keys;
        logic [CNT_W-1:0] kept;    // r^(2K)
        logic [CNT_W-1:0] chunk1;  // r^(2K-1), second key pass
        logic [CNT_W-1:0] fin;     // r^K, final chunk
    } t_job;

endpackage

`default_nettype wire

/* rtl/core/gga_if.sv */
// Handshake channels of the group-average smoothing block.
`default_nettype none

interface gga_sample_if;
    import gga_pkg::*;
    logic    valid;
    logic    ready;
    t_sample data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gga_result_if;
    import gga_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gga_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/gga_front.sv */
// Front end: sample intake, store writes and job setup on the final sample.
`default_nettype none

module gga_front import gga_pkg::*; #(
    parameter int MAX_SAMPLES = 64,
    parameter int MAX_KEYS    = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gga_sample_if.sink  i_sample,
    gga_cfg_if.sink     i_cfg,
    output t_wr         o_wr,
    output logic        o_push,
    output t_job        o_job,
    input  wire logic   i_full,
    input  wire logic   i_done
);

    logic [1:0]       r_key_count;
    logic [CNT_W-1:0] r_loaded;
    logic             r_hold;
    logic             acc;
    logic             room;
    logic [CNT_W-1:0] n;
    logic             two_keys;
    logic [R_W-1:0]   r;
    logic [CNT_W-1:0] r2;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !r_hold && !i_full;
    assign acc  = i_sample.valid && i_sample.ready;
    assign room = r_loaded < CNT_W'(MAX_SAMPLES);
    assign n    = r_loaded + CNT_W'(room);

    assign o_wr.en       = acc && room;
    assign o_wr.addr     = r_loaded[ADDR_W-1:0];
    assign o_wr.keys     = {i_sample.data.key_b, i_sample.data.key_a};
    assign o_wr.feats    = {i_sample.data.feat_d, i_sample.data.feat_c,
                            i_sample.data.feat_b, i_sample.data.feat_a};

    // Zero acts as one key; clamp to the supported key count.
    assign two_keys = (r_key_count >= 2'd2) && (MAX_KEYS >= 2);

    // Largest r with r^(2K) <= n.
    always_comb begin
        r = R_W'(1);
        for (int t = 2; t <= 8; t++) begin
            if (two_keys) begin
                if (CNT_W'(t * t * t * t) <= n && t * t * t * t <= 64)
                    r = R_W'(t);
            end else begin
                if (CNT_W'(t * t) <= n)
                    r = R_W'(t);
            end
        end
    end

    assign r2 = CNT_W'(r * r);
    assign o_job.two_keys = two_keys;
    assign o_job.kept     = two_keys ? CNT_W'(r2 * r2) : r2;
    assign o_job.chunk1   = CNT_W'(r2 * r);
    assign o_job.fin      = two_keys ? r2 : CNT_W'(r);
    assign o_push         = acc && i_sample.data.final_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEYS_RESET;
            r_loaded    <= '0;
            r_hold      <= 1'b0;
        end else begin
            if (i_cfg.valid)
                r_key_count <= i_cfg.data;
            if (acc)
                r_loaded <= i_sample.data.final_sample ? '0 : n;
            // Hold intake while the back end owns the stores.
            if (o_push)
                r_hold <= 1'b1;
            else if (i_done)
                r_hold <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gga_job_fifo.sv */
// Two-entry job queue between front and back end.
`default_nettype none

module gga_job_fifo import gga_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_job       i_job,
    input  wire logic  i_pop,
    output t_job       o_job,
    output logic       o_full,
    output logic       o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full)
            r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wp <= !r_wp;
            if (i_pop && !o_empty)
                r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gga_divider.sv */
// Bit-serial signed divider, quotient truncated toward zero.
`default_nettype none

module gga_divider import gga_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [DIV_W:0]    rem_sh;
    logic              fit;
    logic [SUM_W-1:0]  signed_q;

    assign rem_sh     = {r_rem, r_quo[SUM_W-1]};
    assign fit        = rem_sh >= {1'b0, r_div};
    assign signed_q   = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quotient = signed_q[DATA_W-1:0];
    assign o_done     = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_neg  <= i_dividend < 0;
                r_quo  <= (i_dividend < 0) ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fit ? DIV_W'(rem_sh - {1'b0, r_div}) : rem_sh[DIV_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], fit};
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gga_back.sv */
// Back end: stores, stable key sorts over the order list, chunk means, results.
`default_nettype none

module gga_back import gga_pkg::*; #(
    parameter int MAX_SAMPLES   = 64,
    parameter int MAX_KEYS      = 2,
    parameter int FEATURE_COUNT = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_wr         i_wr,
    input  t_job        i_job,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_done,
    gga_result_if.source o_result
);

    typedef enum logic [4:0] {
        B_IDLE, B_INIT, S_START, S_I_RD, S_I_KEY, S_I_KV, S_J, S_J_K, S_J_C,
        S_I_NEXT, S_RANGE, A_START, A_RD, A_F, A_ACC, A_DIV, A_DW, E_RD, E_OUT,
        B_DONE
    } t_state;

    logic [MAX_KEYS-1:0][DATA_W-1:0]      key_mem  [MAX_SAMPLES];
    logic [FEATURE_COUNT-1:0][DATA_W-1:0] feat_mem [MAX_SAMPLES];
    logic [ADDR_W-1:0]                    ord_mem  [MAX_SAMPLES];

    logic [MAX_KEYS-1:0][DATA_W-1:0]      key_q;
    logic [FEATURE_COUNT-1:0][DATA_W-1:0] feat_q;
    logic [ADDR_W-1:0]                    r_ord_q;

    t_state           r_state;
    logic             r_two_keys;
    logic [CNT_W-1:0] r_kept;
    logic [CNT_W-1:0] r_chunk1;
    logic [CNT_W-1:0] r_fin;
    logic             r_ki;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic [ADDR_W-1:0] r_v;
    logic [ADDR_W-1:0] r_w;
    logic signed [DATA_W-1:0] r_kv;
    logic signed [SUM_W-1:0]  r_sum  [FEATURE_COUNT];
    logic [DATA_W-1:0]        r_mean [FEAT_N];
    logic [1:0]       r_f;
    t_result          r_out;
    logic             r_out_valid;

    logic [CNT_W-1:0]  lo_i;
    logic [CNT_W-1:0]  lo_j;
    logic [CNT_W-1:0]  lo_next;
    logic [ADDR_W-1:0] ord_raddr;
    logic              ord_we;
    logic [ADDR_W-1:0] ord_waddr;
    logic [ADDR_W-1:0] ord_wdata;
    logic signed [DATA_W-1:0] key_sel;
    logic              key_gt;
    logic              out_free;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    assign lo_i    = r_lo + r_i;
    assign lo_j    = r_lo + r_j;
    assign lo_next = r_lo + r_len;
    assign key_sel = (r_ki && MAX_KEYS > 1) ? $signed(key_q[MAX_KEYS-1]) : $signed(key_q[0]);
    assign key_gt  = key_sel > r_kv;
    assign out_free = !r_out_valid || o_result.ready;

    assign o_pop          = (r_state == B_IDLE) && !i_empty;
    assign o_done         = r_state == B_DONE;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_comb begin
        ord_raddr = '0;
        unique case (r_state)
            S_I_RD, A_RD, E_RD, E_OUT: ord_raddr = lo_i[ADDR_W-1:0];
            S_J:                       ord_raddr = ADDR_W'(lo_j - CNT_W'(1));
            default:                   ord_raddr = '0;
        endcase
    end

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = lo_j[ADDR_W-1:0];
        ord_wdata = r_v;
        unique case (r_state)
            B_INIT: begin
                ord_we    = 1'b1;
                ord_waddr = r_i[ADDR_W-1:0];
                ord_wdata = r_i[ADDR_W-1:0];
            end
            S_J: ord_we = r_j == '0;
            S_J_C: begin
                ord_we    = 1'b1;
                ord_wdata = key_gt ? r_w : r_v;
            end
            default: ord_we = 1'b0;
        endcase
    end

    // Sample stores: written by the front end, read through the order list.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int k = 0; k < MAX_KEYS; k++)
                key_mem[i_wr.addr][k] <= i_wr.keys[k];
            for (int f = 0; f < FEATURE_COUNT; f++)
                feat_mem[i_wr.addr][f] <= i_wr.feats[f];
        end
        key_q  <= key_mem[r_ord_q];
        feat_q <= feat_mem[r_ord_q];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        r_ord_q <= ord_mem[ord_raddr];
    end

    gga_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == A_DIV),
        .i_dividend (r_sum[r_f]),
        .i_divisor  (r_fin[DIV_W-1:0]),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result when the output frees up, else drop it once taken.
            if (r_state == E_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (o_result.ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_two_keys <= i_job.two_keys;
                        r_kept     <= i_job.kept;
                        r_chunk1   <= i_job.chunk1;
                        r_fin      <= i_job.fin;
                        r_i        <= '0;
                        r_state    <= B_INIT;
                    end
                end
                B_INIT: begin
                    if (r_i + CNT_W'(1) == r_kept) begin
                        r_lo    <= '0;
                        r_len   <= r_kept;
                        r_ki    <= 1'b0;
                        r_state <= S_START;
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                S_START: begin
                    r_i     <= CNT_W'(1);
                    r_state <= (r_len <= CNT_W'(1)) ? S_RANGE : S_I_RD;
                end
                S_I_RD:  r_state <= S_I_KEY;
                S_I_KEY: begin
                    r_v     <= r_ord_q;
                    r_state <= S_I_KV;
                end
                S_I_KV: begin
                    r_kv    <= key_sel;
                    r_j     <= r_i;
                    r_state <= S_J;
                end
                S_J:     r_state <= (r_j == '0) ? S_I_NEXT : S_J_K;
                S_J_K: begin
                    r_w     <= r_ord_q;
                    r_state <= S_J_C;
                end
                S_J_C: begin
                    // Shift the larger key up; equal keys stop, which keeps ties stable.
                    if (key_gt) begin
                        r_j     <= r_j - CNT_W'(1);
                        r_state <= S_J;
                    end else begin
                        r_state <= S_I_NEXT;
                    end
                end
                S_I_NEXT: begin
                    if (r_i + CNT_W'(1) == r_len) begin
                        r_state <= S_RANGE;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_I_RD;
                    end
                end
                S_RANGE: begin
                    if (lo_next != r_kept) begin
                        r_lo    <= lo_next;
                        r_state <= S_START;
                    end else if (!r_ki && r_two_keys) begin
                        r_ki    <= 1'b1;
                        r_lo    <= '0;
                        r_len   <= r_chunk1;
                        r_state <= S_START;
                    end else begin
                        r_lo    <= '0;
                        r_len   <= r_fin;
                        r_state <= A_START;
                    end
                end
                A_START: begin
                    r_i <= '0;
                    r_f <= '0;
                    for (int f = 0; f < FEATURE_COUNT; f++)
                        r_sum[f] <= '0;
                    for (int f = 0; f < FEAT_N; f++)
                        r_mean[f] <= '0;
                    r_state <= A_RD;
                end
                A_RD: r_state <= A_F;
                A_F:  r_state <= A_ACC;
                A_ACC: begin
                    for (int f = 0; f < FEATURE_COUNT; f++)
                        r_sum[f] <= r_sum[f] + SUM_W'($signed(feat_q[f]));
                    if (r_i + CNT_W'(1) == r_len) begin
                        r_i     <= '0;
                        r_state <= A_DIV;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= A_RD;
                    end
                end
                A_DIV: r_state <= A_DW;
                A_DW: begin
                    if (div_done) begin
                        r_mean[r_f] <= div_q;
                        if (r_f == 2'(FEATURE_COUNT - 1)) begin
                            r_state <= E_RD;
                        end else begin
                            r_f     <= r_f + 2'd1;
                            r_state <= A_DIV;
                        end
                    end
                end
                E_RD: r_state <= E_OUT;
                E_OUT: begin
                    if (out_free) begin
                        r_out.mean_a      <= r_mean[0];
                        r_out.mean_b      <= r_mean[1];
                        r_out.mean_c      <= r_mean[2];
                        r_out.mean_d      <= r_mean[3];
                        r_out.source_slot <= r_ord_q;
                        r_out.run_end     <= lo_i + CNT_W'(1) == r_kept;
                        if (r_i + CNT_W'(1) != r_len) begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= E_RD;
                        end else if (lo_next == r_kept) begin
                            r_state <= B_DONE;
                        end else begin
                            r_lo    <= lo_next;
                            r_state <= A_START;
                        end
                    end
                end
                B_DONE: r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_range_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START || r_state == A_START) |->
            (8'(r_lo) + 8'(r_len) <= 8'(r_kept)))
        else $error("range runs past the kept samples");

    a_inner_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_J || r_state == S_J_K || r_state == S_J_C) |-> (r_j <= r_i))
        else $error("insertion index ahead of outer index");

    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV) |-> (r_fin != '0 && r_fin <= CNT_W'(8)))
        else $error("bad chunk size at divide");

    a_single_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DONE) |=> (r_state == B_IDLE))
        else $error("done not followed by idle");

endmodule

`default_nettype wire

/* rtl/core/grid_group_average_smoothing.sv */
// Top level of the grid group-average smoothing block.
// Samples transfer in one per cycle while intake is not held, and are written to
// slot stores in arrival order; up to MAX_SAMPLES are kept and later ones are
// dropped, though a final mark on a dropped sample still starts grouping. On the
// final sample the front end picks the largest r with r^(2K) not above the count
// and queues a job; intake then holds until the back end finishes that job. The
// back end sorts the first r^(2K) slots stably by key 0 (and, with two keys, each
// of r chunks by key 1) with an insertion sort over an order list. Each final
// chunk of r^K samples is then summed and divided by a bit-serial divider one
// feature at a time, and its results transfer out one at a time, slower under
// output stalls, with run_end marking the last of the set.
// Means truncate toward zero; features past FEATURE_COUNT read as zero.
// key_count 0 acts as one key.
`default_nettype none

module grid_group_average_smoothing import gga_pkg::*; #(
    parameter int MAX_SAMPLES   = 64,
    parameter int MAX_KEYS      = 2,
    parameter int FEATURE_COUNT = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gga_sample_if.sink    i_sample,
    gga_cfg_if.sink       i_cfg,
    gga_result_if.source  o_result
);

    t_wr  wr;
    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;
    logic done;

    // Intake, configuration and job setup.
    gga_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_KEYS    (MAX_KEYS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (i_cfg),
        .o_wr     (wr),
        .o_push   (push),
        .o_job    (push_job),
        .i_full   (full),
        .i_done   (done)
    );

    // Decouple job setup from the sort and average engine.
    gga_job_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // Sort, average and emit.
    gga_back #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .MAX_KEYS      (MAX_KEYS),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_job    (pop_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_done   (done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* tb/grid_group_average_smoothing_tb.sv */
// Testbench for the grid group-average smoothing block: directed and random sample sets against a scoreboard.
`default_nettype none

module grid_group_average_smoothing_tb;
    import gga_pkg::*;

    localparam int MAX_SET = 64;
    localparam logic [1:0] KEYS_ZERO = 2'd0;
    localparam logic [1:0] KEYS_ONE  = 2'd1;
    localparam logic [1:0] KEYS_TWO  = 2'd2;
    localparam logic [1:0] KEYS_OVER = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gga_sample_if sample_ch ();
    gga_result_if result_ch ();
    gga_cfg_if    cfg_ch ();

    grid_group_average_smoothing uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (result_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expectation stores.
    t_sample pending_samples[$];
    t_result expected_means[$];

    // Predictor copy of the block state.
    t_sample loaded_set[MAX_SET];
    int      loaded_n;
    logic [1:0] key_sel;

    int failures;
    int sets_done;
    int results_seen;

    logic [1:0] cfg_pending;
    bit         cfg_req;

    // Return key ki of a loaded sample as a signed value.
    function automatic logic signed [31:0] key_of(int slot, int ki);
        return ki == 0 ? loaded_set[slot].key_a : loaded_set[slot].key_b;
    endfunction

    function automatic logic signed [31:0] feat_of(int slot, int f);
        case (f)
            0: return loaded_set[slot].feat_a;
            1: return loaded_set[slot].feat_b;
            2: return loaded_set[slot].feat_c;
            default: return loaded_set[slot].feat_d;
        endcase
    endfunction

    // Load one sample; on the final mark, group the set and queue its means.
    task automatic predict_grouping(t_sample s);
        int k, r, kept, chunk, ki, c, i, j, f, p, v;
        int order[MAX_SET];
        longint sum;
        logic signed [31:0] mean[4];
        t_result res;
        if (loaded_n < MAX_SET) begin
            loaded_set[loaded_n] = s;
            loaded_n++;
        end
        if (!s.final_sample) return;
        k = (key_sel == KEYS_ZERO) ? 1 : (key_sel > KEYS_TWO ? 2 : key_sel);
        r = 1;
        forever begin
            p = 1;
            for (i = 0; i < 2 * k; i++) p *= (r + 1);
            if (p > loaded_n) break;
            r++;
        end
        kept = 1;
        for (i = 0; i < 2 * k; i++) kept *= r;
        for (i = 0; i < kept; i++) order[i] = i;
        chunk = kept;
        for (ki = 0; ki < k; ki++) begin
            for (c = 0; c < kept / chunk; c++) begin
                // stable insertion sort within the chunk
                for (i = 1; i < chunk; i++) begin
                    v = order[c * chunk + i];
                    j = i;
                    while (j > 0 && key_of(order[c * chunk + j - 1], ki) > key_of(v, ki)) begin
                        order[c * chunk + j] = order[c * chunk + j - 1];
                        j--;
                    end
                    order[c * chunk + j] = v;
                end
            end
            chunk /= r;
        end
        p = 0;
        for (c = 0; c < kept / chunk; c++) begin
            for (f = 0; f < 4; f++) begin
                sum = 0;
                for (i = 0; i < chunk; i++) sum += longint'(feat_of(order[c * chunk + i], f));
                mean[f] = 32'(sum / chunk);
            end
            for (i = 0; i < chunk; i++) begin
                res.mean_a = mean[0];
                res.mean_b = mean[1];
                res.mean_c = mean[2];
                res.mean_d = mean[3];
                res.source_slot = 6'(order[c * chunk + i]);
                res.run_end = (p + 1 == kept);
                expected_means.push_back(res);
                p++;
            end
        end
        loaded_n = 0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 7)) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_sample rand_sample(bit fin, bit few_keys);
        t_sample s;
        s.key_a  = few_keys ? 32'($urandom_range(0, 3)) : rand_word();
        s.key_b  = few_keys ? 32'($urandom_range(0, 3)) : rand_word();
        s.feat_a = rand_word();
        s.feat_b = rand_word();
        s.feat_c = rand_word();
        s.feat_d = rand_word();
        s.final_sample = fin;
        return s;
    endfunction

    // Driver: transfer queued samples with random gaps.
    int drive_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            sample_ch.data  <= '0;
            drive_gap <= $urandom_range(0, 11);
        end else if (sample_ch.valid && sample_ch.ready) begin
            predict_grouping(sample_ch.data);
            void'(pending_samples.pop_front());
            drive_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (drive_gap == 0 && pending_samples.size() > 0) begin
                sample_ch.data <= pending_samples[0];
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end else if (!sample_ch.valid) begin
            if (drive_gap > 0) begin
                drive_gap <= drive_gap - 1;
            end else if (pending_samples.size() > 0) begin
                sample_ch.valid <= 1'b1;
                sample_ch.data  <= pending_samples[0];
            end
        end
    end

    // Monitor: compare each transferred result with the oldest expectation.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (expected_means.size() == 0) begin
                    $error("unexpected result, source_slot %0d", result_ch.data.source_slot);
                    failures++;
                end else begin
                    t_result e;
                    e = expected_means.pop_front();
                    if (e.mean_a !== result_ch.data.mean_a) begin
                        $error("mean_a expected %0d actual %0d", e.mean_a, result_ch.data.mean_a);
                        failures++;
                    end
                    if (e.mean_b !== result_ch.data.mean_b) begin
                        $error("mean_b expected %0d actual %0d", e.mean_b, result_ch.data.mean_b);
                        failures++;
                    end
                    if (e.mean_c !== result_ch.data.mean_c) begin
                        $error("mean_c expected %0d actual %0d", e.mean_c, result_ch.data.mean_c);
                        failures++;
                    end
                    if (e.mean_d !== result_ch.data.mean_d) begin
                        $error("mean_d expected %0d actual %0d", e.mean_d, result_ch.data.mean_d);
                        failures++;
                    end
                    if (e.source_slot !== result_ch.data.source_slot) begin
                        $error("source_slot expected %0d actual %0d",
                               e.source_slot, result_ch.data.source_slot);
                        failures++;
                    end
                    if (e.run_end !== result_ch.data.run_end) begin
                        $error("run_end expected %0d actual %0d", e.run_end, result_ch.data.run_end);
                        failures++;
                    end
                end
                // draw a new stall per result; some stretches run without stalls
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
                result_ch.ready <= (stall_left == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Configuration writer, used only while the block is idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.data  <= KEYS_RESET;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            key_sel = cfg_ch.data;
            cfg_ch.valid <= 1'b0;
            cfg_req = 1'b0;
        end else if (cfg_req && !cfg_ch.valid) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= cfg_pending;
        end
    end

    task automatic wait_idle();
        while (pending_samples.size() > 0 || expected_means.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_keys(logic [1:0] value);
        cfg_pending = value;
        cfg_req = 1'b1;
        while (cfg_req) @(posedge i_clk);
    endtask

    task automatic queue_set(int n, bit few_keys);
        for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample(i == n - 1, few_keys));
    endtask

    initial begin
        t_sample s;
        failures = 0;
        loaded_n = 0;
        key_sel = KEYS_RESET;
        cfg_req = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a lone final sample, extreme words, and ties in the keys.
        s = '{key_a: 32'h7fff_ffff, key_b: 32'h8000_0000, feat_a: 32'h8000_0000,
              feat_b: 32'h7fff_ffff, feat_c: '0, feat_d: 32'hffff_ffff, final_sample: 1'b1};
        pending_samples.push_back(s);
        wait_idle();
        for (int i = 0; i < 16; i++) begin
            s = '{key_a: (i % 2) ? 32'h7fff_ffff : 32'h8000_0000,
                  key_b: (i % 3) ? 32'h8000_0000 : 32'h7fff_ffff,
                  feat_a: 32'h8000_0000, feat_b: 32'h7fff_ffff,
                  feat_c: (i % 2) ? 32'hffff_ffff : 32'h0000_0001, feat_d: ~32'(i),
                  final_sample: (i == 15)};
            pending_samples.push_back(s);
        end
        wait_idle();

        // One key, with the zero setting acting as one key.
        write_keys(KEYS_ONE);
        queue_set(4, 1'b1);
        queue_set(9, 1'b0);
        wait_idle();
        write_keys(KEYS_ZERO);
        queue_set(16, 1'b1);
        wait_idle();

        // Overfull set: samples past the store are dropped, the final mark still counts.
        write_keys(KEYS_ONE);
        queue_set(70, 1'b0);
        wait_idle();

        // Two keys, including the out-of-range setting.
        write_keys(KEYS_OVER);
        queue_set(20, 1'b1);
        wait_idle();
        write_keys(KEYS_TWO);
        for (int i = 0; i < 3; i++) begin
            queue_set($urandom_range(1, 20), $urandom_range(0, 1));
            wait_idle();
        end

        $display("Covered %0d sets and %0d results over key settings 0..3, incl. an overfull set.",
                 sets_done, results_seen);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready && result_ch.data.run_end) sets_done++;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
rtl/core/gga_pkg.sv
rtl/core/gga_if.sv
rtl/core/gga_front.sv
rtl/core/gga_job_fifo.sv
rtl/core/gga_divider.sv
rtl/core/gga_back.sv
rtl/core/grid_group_average_smoothing.sv
tb/grid_group_average_smoothing_tb.sv
